// File: rtl/msrd_pkg.sv
// Package with the request and result types and constants of the motor speed ramp block.
package msrd_pkg;

  localparam logic [11:0] SpeedStop  = 12'd2047;
  localparam logic [11:0] RevSpan    = 12'd2046;
  localparam logic [15:0] TickMax    = 16'hFFFF;

  localparam int unsigned RecipShift = 34;
  localparam logic [23:0] RecipRev   = 24'd8396809;

  localparam logic [10:0] DeadzoneRst = 11'd100;
  localparam logic [11:0] RampStepRst = 12'd15;
  localparam logic [15:0] IntervalRst = 16'd5;
  localparam logic [11:0] MaxDutyRst  = 12'd600;

  localparam logic [1:0] RegDeadzone = 2'd0;
  localparam logic [1:0] RegRampStep = 2'd1;
  localparam logic [1:0] RegInterval = 2'd2;
  localparam logic [1:0] RegMaxDuty  = 2'd3;

  localparam logic CmdSet  = 1'b0;
  localparam logic CmdTick = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [11:0] speed_command;
  } msrd_req_t;

  typedef struct packed {
    logic        drive_reverse;
    logic [11:0] duty;
    logic [11:0] ramped_speed;
  } msrd_rsp_t;

endpackage

// File: rtl/motor_speed_ramp_deadzone.sv
// Top level of the slew-rate limited motor speed command with deadzone.
// The block takes one request per clock cycle while ready is high: a set command stores
// a new target speed, and a millisecond tick advances the elapsed counter and, once the
// count exceeds the update interval, moves the ramped speed one step toward the target.
// Target, ramped speed and counter are updated in the cycle that accepts the request,
// so requests may follow each other back to back. Only an updating tick gives a
// result; it passes from the a stage register through the b stage register to the
// output register; duty scaling takes one registered multiplication by max_duty and
// one by a fixed reciprocal for the reverse range. A full output register that is not
// taken stalls the scaling stages, and ready falls only once they are full. Registers
// are to be written through the APB port while no request is in flight; unenforced.
module motor_speed_ramp_deadzone
  import msrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  msrd_req_t   in_req_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output msrd_rsp_t   out_rsp_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [10:0] deadzone_q;
  logic [11:0] ramp_step_q;
  logic [15:0] interval_q;
  logic [11:0] max_duty_q;

  logic [11:0] target_q, target_d;
  logic [11:0] current_q, current_d;
  logic [15:0] elapsed_q, elapsed_d;

  logic        a_vld_q, a_vld_d;
  logic        a_rev_q, a_rev_d;
  logic [11:0] a_spd_q;
  logic [11:0] a_diff_q, a_diff_d;

  logic        b_vld_q;
  logic        b_rev_q;
  logic [11:0] b_spd_q;
  logic [22:0] b_prod_q;

  logic        out_vld_q;
  msrd_rsp_t   out_q;

  logic        en_out, en_b, en_a, accept;
  logic        cfg_wr;
  logic [11:0] cmd_dist;
  logic [15:0] elapsed_inc;
  logic [12:0] step_sum, step_tgt;
  logic [11:0] ramped;
  logic [23:0] full_prod;
  logic [46:0] recip_prod;
  logic [11:0] duty_d;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      RegDeadzone: prdata = {21'd0, deadzone_q};
      RegRampStep: prdata = {20'd0, ramp_step_q};
      RegInterval: prdata = {16'd0, interval_q};
      RegMaxDuty:  prdata = {20'd0, max_duty_q};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q  <= DeadzoneRst;
      ramp_step_q <= RampStepRst;
      interval_q  <= IntervalRst;
      max_duty_q  <= MaxDutyRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegDeadzone: deadzone_q  <= pwdata[10:0];
        RegRampStep: ramp_step_q <= pwdata[11:0];
        RegInterval: interval_q  <= pwdata[15:0];
        RegMaxDuty:  max_duty_q  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  assign en_out     = !out_vld_q || out_ready_i;
  assign en_b       = !b_vld_q || en_out;
  assign en_a       = !a_vld_q || en_b;
  assign in_ready_o = en_a;
  assign accept     = in_valid_i && en_a;

  assign cmd_dist = (in_req_i.speed_command >= SpeedStop)
                    ? (in_req_i.speed_command - SpeedStop)
                    : (SpeedStop - in_req_i.speed_command);
  assign elapsed_inc = (elapsed_q == TickMax) ? elapsed_q : elapsed_q + 16'd1;
  assign step_sum    = {1'b0, current_q} + {1'b0, ramp_step_q};
  assign step_tgt    = {1'b0, target_q} + {1'b0, ramp_step_q};

  always_comb begin
    if (current_q < target_q) begin
      ramped = (step_sum > {1'b0, target_q}) ? target_q : step_sum[11:0];
    end else if (current_q > target_q) begin
      ramped = ({1'b0, current_q} < step_tgt) ? target_q : current_q - ramp_step_q;
    end else begin
      ramped = current_q;
    end
  end

  always_comb begin
    target_d  = target_q;
    current_d = current_q;
    elapsed_d = elapsed_q;
    a_vld_d   = 1'b0;
    if (accept) begin
      unique case (in_req_i.cmd)
        CmdSet: begin
          target_d = (cmd_dist < {1'b0, deadzone_q}) ? SpeedStop : in_req_i.speed_command;
        end
        CmdTick: begin
          if (elapsed_inc <= interval_q) begin
            elapsed_d = elapsed_inc;
          end else begin
            elapsed_d = 16'd0;
            current_d = ramped;
            a_vld_d   = 1'b1;
          end
        end
        default: ;
      endcase
    end
    a_rev_d  = ramped < SpeedStop;
    a_diff_d = a_rev_d ? (RevSpan - ramped) : (ramped - SpeedStop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= SpeedStop;
      current_q <= SpeedStop;
      elapsed_q <= 16'd0;
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      target_q  <= target_d;
      current_q <= current_d;
      elapsed_q <= elapsed_d;
      if (en_a) begin
        a_vld_q <= a_vld_d;
      end
      if (en_b) begin
        b_vld_q <= a_vld_q;
      end
      if (en_out) begin
        out_vld_q <= b_vld_q;
      end
    end
  end

  assign full_prod  = a_diff_q * max_duty_q;
  assign recip_prod = b_prod_q * RecipRev;
  assign duty_d     = b_rev_q ? recip_prod[RecipShift+11:RecipShift] : b_prod_q[22:11];

  always_ff @(posedge clk_i) begin
    if (en_a && a_vld_d) begin
      a_rev_q  <= a_rev_d;
      a_spd_q  <= ramped;
      a_diff_q <= a_diff_d;
    end
    if (en_b && a_vld_q) begin
      b_rev_q  <= a_rev_q;
      b_spd_q  <= a_spd_q;
      b_prod_q <= full_prod[22:0];
    end
    if (en_out && b_vld_q) begin
      out_q.drive_reverse <= b_rev_q;
      out_q.duty          <= duty_d;
      out_q.ramped_speed  <= b_spd_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

endmodule
